@@ src/lstmd_pkg.sv @@
// Package for the light sensor trimmed-mean dimmer.
// Holds window sizing, derived widths, register indexes and sequencer types.
// No dependencies.
package lstmd_pkg;

    localparam int WINDOW = 16;
    localparam int MEDIAN = 8;

    localparam int SMP_W = 12;
    localparam int LVL_W = 8;
    localparam int AW    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam int SUM_W = SMP_W + CNT_W;
    localparam int DIV_W = (SUM_W > 20) ? SUM_W : 20;
    localparam int DC_W  = $clog2(DIV_W + 1);
    localparam int IDX_W = 2;

    localparam logic [IDX_W-1:0] REG_SENSOR_MIN      = 2'd0;
    localparam logic [IDX_W-1:0] REG_SENSOR_MAX      = 2'd1;
    localparam logic [IDX_W-1:0] REG_SENSITIVITY     = 2'd2;
    localparam logic [IDX_W-1:0] REG_USER_BRIGHTNESS = 2'd3;

    localparam logic [SMP_W-1:0] FULL_SCALE = 12'd4095;
    localparam logic [LVL_W-1:0] LEVEL_MAX  = 8'd255;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_MSUM  = 9'b000000010,
        S_RLOAD = 9'b000000100,
        S_RCAND = 9'b000001000,
        S_RANK  = 9'b000010000,
        S_MUL   = 9'b000100000,
        S_DIV   = 9'b001000000,
        S_POST  = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    typedef enum logic [1:0] {
        PH_MEAN  = 2'd0,
        PH_SCALE = 2'd1,
        PH_TRIM  = 2'd2,
        PH_MAP   = 2'd3
    } t_phase;

endpackage

@@ src/light_sensor_trimmed_mean_dimmer_unit.sv @@
// Top level of the light sensor trimmed-mean dimmer.
// Window memory, rank sweep, shared restoring divider and sequencer.
// Depends on lstmd_pkg.

// One 12-bit light sample in, one dimming result out. The block keeps the
// newest WINDOW samples. Until MEDIAN samples are held it reports their plain
// mean scaled to 0..255; afterwards it averages the middle MEDIAN samples in
// sorted order, clamps that average into the sensor_min..sensor_max span and
// maps it inversely onto sensitivity..0. Work on one sample runs under a
// sequencer with o_ready low. The trimmed path sweeps ranks over the
// single-port window memory, then runs the one-bit-per-cycle divider twice,
// or once when sensor_min equals sensor_max; the plain-mean path sums the
// held samples and also runs the divider twice.
// Configuration may be written at any time the block is idle.
module light_sensor_trimmed_mean_dimmer_unit
    import lstmd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [SMP_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [SMP_W-1:0]   i_light_sample,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [LVL_W-1:0]   o_sensor_level,
    output logic               o_level_changed,
    output logic [LVL_W-1:0]   o_brightness_target
);

    // configuration registers
    logic [SMP_W-1:0] r_smin, r_smax;
    logic [LVL_W-1:0] r_sens, r_ubr;

    // window state
    logic [SMP_W-1:0] r_mem [WINDOW];
    logic [SMP_W-1:0] r_rd;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [AW-1:0]    r_oldest, n_oldest, w_waddr, w_raddr;
    logic [LVL_W-1:0] r_prev;

    // sequencer
    t_state           r_state;
    t_phase           r_phase;
    logic [CNT_W-1:0] r_i, r_j, r_rank, n_rank;
    logic [SMP_W-1:0] r_cand;
    logic [SUM_W-1:0] r_sum;
    logic [SMP_W-1:0] r_dl, r_dd;
    logic [LVL_W-1:0] r_level;

    // divider
    logic [DIV_W-1:0] r_quo;
    logic [SMP_W-1:0] r_rem, r_dvs;
    logic [DC_W-1:0]  r_dcnt;
    logic [SMP_W:0]   w_trial;

    // output register
    logic             r_ovalid;
    logic [LVL_W-1:0] r_olvl, r_otgt;
    logic             r_ochg;

    // clamp and map helpers
    logic [SMP_W-1:0] w_avg, w_lo, w_hi, w_clamp;
    logic             w_in_trim, w_last_j;
    int               w_off;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign o_valid     = r_ovalid;
    assign o_sensor_level      = r_olvl;
    assign o_level_changed     = r_ochg;
    assign o_brightness_target = r_otgt;

    // slot for the incoming sample and updated fill/oldest
    always_comb begin
        n_fill   = r_fill;
        n_oldest = r_oldest;
        if (32'(r_fill) < WINDOW) begin
            w_waddr = r_fill[AW-1:0];
            n_fill  = r_fill + 1'b1;
        end else begin
            w_waddr = r_oldest;
            n_oldest = (32'(r_oldest) == WINDOW - 1) ? '0 : r_oldest + 1'b1;
        end
    end

    // read address: candidate fetch or sweep position
    always_comb begin
        if (r_state == S_RLOAD) begin
            w_raddr = r_i[AW-1:0];
        end else begin
            w_raddr = r_j[AW-1:0];
        end
    end

    // rank update for the element read in the previous sweep cycle
    always_comb begin
        n_rank = r_rank;
        if ((r_rd < r_cand) || ((r_rd == r_cand) && ((r_j - 1'b1) < r_i))) begin
            n_rank = r_rank + 1'b1;
        end
    end

    assign w_last_j  = (r_j == r_fill);
    assign w_off     = (32'(r_fill) - MEDIAN) / 2;
    assign w_in_trim = (int'(n_rank) >= w_off) && (int'(n_rank) < w_off + MEDIAN);

    // divider step
    assign w_trial = {r_rem, r_quo[DIV_W-1]};

    // clamp the trimmed average into the span of the two bounds
    always_comb begin
        w_avg = r_quo[SMP_W-1:0];
        w_lo  = (r_smin < r_smax) ? r_smin : r_smax;
        w_hi  = (r_smin < r_smax) ? r_smax : r_smin;
        w_clamp = w_avg;
        if (w_avg < w_lo) w_clamp = w_lo;
        if (w_avg > w_hi) w_clamp = w_hi;
    end

    // window memory: write on an input beat, registered read
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_mem[w_waddr] <= i_light_sample;
        end
        r_rd <= r_mem[w_raddr];
    end

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smin <= '0;
            r_smax <= FULL_SCALE;
            r_sens <= LEVEL_MAX;
            r_ubr  <= 8'd128;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_SENSOR_MIN:      r_smin <= i_cfg_data;
                REG_SENSOR_MAX:      r_smax <= i_cfg_data;
                REG_SENSITIVITY:     r_sens <= i_cfg_data[LVL_W-1:0];
                REG_USER_BRIGHTNESS: r_ubr  <= i_cfg_data[LVL_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_phase  <= PH_MEAN;
            r_fill   <= '0;
            r_oldest <= '0;
            r_prev   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            // drop a result once taken, unless a new one replaces it
            if (r_ovalid && i_ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_fill   <= n_fill;
                        r_oldest <= n_oldest;
                        r_j      <= '0;
                        r_i      <= '0;
                        r_sum    <= '0;
                        if (32'(n_fill) < MEDIAN) begin
                            r_state <= S_MSUM;
                        end else begin
                            r_state <= S_RLOAD;
                        end
                    end
                end
                // accumulate the held samples for the plain mean
                S_MSUM: begin
                    if (r_j != '0) begin
                        r_sum <= r_sum + SUM_W'(r_rd);
                    end
                    r_j <= r_j + 1'b1;
                    if (w_last_j) begin
                        r_quo   <= DIV_W'(r_sum + SUM_W'(r_rd));
                        r_dvs   <= SMP_W'(r_fill);
                        r_rem   <= '0;
                        r_dcnt  <= DC_W'(DIV_W);
                        r_phase <= PH_MEAN;
                        r_state <= S_DIV;
                    end
                end
                // fetch the candidate sample
                S_RLOAD: begin
                    r_state <= S_RCAND;
                end
                S_RCAND: begin
                    r_cand  <= r_rd;
                    r_j     <= '0;
                    r_rank  <= '0;
                    r_state <= S_RANK;
                end
                // count samples ranked below the candidate
                S_RANK: begin
                    r_j <= r_j + 1'b1;
                    if (r_j != '0) begin
                        r_rank <= n_rank;
                    end
                    if (w_last_j) begin
                        if (w_in_trim) begin
                            r_sum <= r_sum + SUM_W'(r_cand);
                        end
                        if (r_i == r_fill - 1'b1) begin
                            r_quo   <= DIV_W'(w_in_trim ? r_sum + SUM_W'(r_cand) : r_sum);
                            r_dvs   <= SMP_W'(MEDIAN);
                            r_rem   <= '0;
                            r_dcnt  <= DC_W'(DIV_W);
                            r_phase <= PH_TRIM;
                            r_state <= S_DIV;
                        end else begin
                            r_i     <= r_i + 1'b1;
                            r_state <= S_RLOAD;
                        end
                    end
                end
                // scale the offset from sensor_min by sensitivity
                S_MUL: begin
                    r_quo   <= DIV_W'(r_dl) * DIV_W'(r_sens);
                    r_dvs   <= r_dd;
                    r_rem   <= '0;
                    r_dcnt  <= DC_W'(DIV_W);
                    r_phase <= PH_MAP;
                    r_state <= S_DIV;
                end
                // one quotient bit a cycle
                S_DIV: begin
                    if (w_trial >= {1'b0, r_dvs}) begin
                        r_rem <= SMP_W'(w_trial - {1'b0, r_dvs});
                        r_quo <= {r_quo[DIV_W-2:0], 1'b1};
                    end else begin
                        r_rem <= w_trial[SMP_W-1:0];
                        r_quo <= {r_quo[DIV_W-2:0], 1'b0};
                    end
                    r_dcnt <= r_dcnt - 1'b1;
                    if (r_dcnt == DC_W'(1)) begin
                        r_state <= S_POST;
                    end
                end
                // advance to the next division or finish
                S_POST: begin
                    case (r_phase)
                        PH_MEAN: begin
                            r_quo   <= DIV_W'(r_quo[SMP_W-1:0]) * DIV_W'(LEVEL_MAX);
                            r_dvs   <= FULL_SCALE;
                            r_rem   <= '0;
                            r_dcnt  <= DC_W'(DIV_W);
                            r_phase <= PH_SCALE;
                            r_state <= S_DIV;
                        end
                        PH_SCALE: begin
                            r_level <= r_quo[LVL_W-1:0];
                            r_state <= S_OUT;
                        end
                        PH_TRIM: begin
                            if (r_smin == r_smax) begin
                                r_level <= r_sens;
                                r_state <= S_OUT;
                            end else begin
                                r_dl <= (r_smin < r_smax) ? w_clamp - r_smin : r_smin - w_clamp;
                                r_dd <= (r_smin < r_smax) ? r_smax - r_smin : r_smin - r_smax;
                                r_state <= S_MUL;
                            end
                        end
                        default: begin
                            r_level <= r_sens - r_quo[LVL_W-1:0];
                            r_state <= S_OUT;
                        end
                    endcase
                end
                // hold until the output register is free
                S_OUT: begin
                    if (!r_ovalid || i_ready) begin
                        r_ovalid <= 1'b1;
                        r_olvl   <= r_level;
                        r_ochg   <= (r_level != r_prev);
                        r_otgt   <= (r_ubr > r_level) ? r_ubr - r_level : '0;
                        r_prev   <= r_level;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

@@ src/lstmd_checker.sv @@
// Port checker for the light sensor trimmed-mean dimmer, bound to the top level.
// Depends on lstmd_pkg and light_sensor_trimmed_mean_dimmer_unit.
module lstmd_checker
    import lstmd_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_valid,
    input logic             o_ready,
    input logic             o_valid,
    input logic             i_ready,
    input logic [LVL_W-1:0] o_sensor_level,
    input logic             o_level_changed,
    input logic [LVL_W-1:0] o_brightness_target
);

    // a stalled result beat holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_sensor_level)
            && $stable(o_level_changed) && $stable(o_brightness_target))
        else $error("result beat changed while stalled");

    // an input beat starts work, so the block drops ready
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after an input beat");

    // reset leaves the block idle with no result
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && o_ready)
        else $error("block not idle after reset");

endmodule

bind light_sensor_trimmed_mean_dimmer_unit lstmd_checker u_lstmd_checker (.*);

@@ tb/sv/light_sensor_trimmed_mean_dimmer_unit_checker.sv @@
// Checker for the light sensor trimmed-mean dimmer: watches the three channels,
// predicts each dimming result and compares it with the block's output beats.
// Depends on lstmd_pkg.
module light_sensor_trimmed_mean_dimmer_unit_checker
    import lstmd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic [IDX_W-1:0]   i_cfg_index,
    input  logic [SMP_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    input  logic               i_ready_in,
    input  logic [SMP_W-1:0]   i_light_sample,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  logic [LVL_W-1:0]   i_sensor_level,
    input  logic               i_level_changed,
    input  logic [LVL_W-1:0]   i_brightness_target,
    output int                 o_fail_count,
    output int                 o_pending
);

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic             changed;
        logic [LVL_W-1:0] target;
    } t_dim_result;

    // Shadow registers and window state
    logic [SMP_W-1:0] sh_min, sh_max;
    logic [LVL_W-1:0] sh_sens, sh_user;
    logic [SMP_W-1:0] win [WINDOW];
    int               held, head;
    logic [LVL_W-1:0] last_level;
    t_dim_result      awaited_levels [$];

    // Push one sample into the window and work out the result it causes
    function automatic t_dim_result predict_dimming(logic [SMP_W-1:0] smp);
        int          srt [WINDOW];
        int          sum, avg, lo, hi, off, v, j, lvl;
        longint      num, den;
        t_dim_result r;
        if (held < WINDOW) begin
            win[(head + held) % WINDOW] = smp;
            held++;
        end else begin
            win[head] = smp;
            head = (head + 1) % WINDOW;
        end
        sum = 0;
        if (held < MEDIAN) begin
            for (int i = 0; i < held; i++) sum += win[i];
            lvl = (sum / held) * 255 / 4095;
        end else begin
            // copy the held samples oldest first, sort them ascending, then average the middle run
            for (int i = 0; i < held; i++) srt[i] = win[(head + i) % WINDOW];
            for (int i = 1; i < held; i++) begin
                v = srt[i];
                j = i;
                while (j > 0 && srt[j-1] > v) begin
                    srt[j] = srt[j-1];
                    j--;
                end
                srt[j] = v;
            end
            off = (held - MEDIAN) / 2;
            for (int i = 0; i < MEDIAN; i++) sum += srt[off + i];
            avg = sum / MEDIAN;
            lo = (sh_min < sh_max) ? sh_min : sh_max;
            hi = (sh_min < sh_max) ? sh_max : sh_min;
            if (avg < lo) avg = lo;
            if (avg > hi) avg = hi;
            if (sh_min == sh_max) begin
                lvl = sh_sens;
            end else begin
                num = (longint'(avg) - longint'(sh_min)) * -longint'(sh_sens);
                den = longint'(sh_max) - longint'(sh_min);
                lvl = int'(num / den) + sh_sens;
            end
        end
        r.level   = lvl[LVL_W-1:0];
        r.changed = (r.level != last_level);
        r.target  = (sh_user > r.level) ? sh_user - r.level : '0;
        last_level = r.level;
        return r;
    endfunction

    // Track configuration beats, predict on input beats, compare on output beats
    always @(posedge i_clk) begin
        t_dim_result got, want;
        if (!i_rst_n) begin
            sh_min       <= 12'd0;
            sh_max       <= FULL_SCALE;
            sh_sens      <= LEVEL_MAX;
            sh_user      <= 8'd128;
            held         = 0;
            head         = 0;
            last_level   = '0;
            awaited_levels.delete();
            o_fail_count <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SENSOR_MIN:      sh_min  <= i_cfg_data;
                    REG_SENSOR_MAX:      sh_max  <= i_cfg_data;
                    REG_SENSITIVITY:     sh_sens <= i_cfg_data[LVL_W-1:0];
                    REG_USER_BRIGHTNESS: sh_user <= i_cfg_data[LVL_W-1:0];
                    default: ;
                endcase
            end
            if (i_valid && i_ready_in)
                awaited_levels.push_back(predict_dimming(i_light_sample));
            if (i_out_valid && i_out_ready) begin
                got = '{i_sensor_level, i_level_changed, i_brightness_target};
                if (awaited_levels.size() == 0) begin
                    $display("%0t: unexpected result beat level=%0d changed=%0d target=%0d",
                             $time, got.level, got.changed, got.target);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = awaited_levels.pop_front();
                    if (got != want) begin
                        $display({"%0t: mismatch level exp %0d got %0d, ",
                                  "changed exp %0d got %0d, target exp %0d got %0d"},
                                 $time, want.level, got.level, want.changed, got.changed,
                                 want.target, got.target);
                        o_fail_count <= o_fail_count + 1;
                    end
                end
            end
        end
        o_pending <= awaited_levels.size();
    end

endmodule

@@ tb/sv/light_sensor_trimmed_mean_dimmer_unit_test.sv @@
// Testbench top for the light sensor trimmed-mean dimmer: clock, reset,
// sample and register stimulus, receiver stalls, watchdog and verdict.
// Depends on lstmd_pkg, the block and light_sensor_trimmed_mean_dimmer_unit_checker.
module light_sensor_trimmed_mean_dimmer_unit_test;
    import lstmd_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [IDX_W-1:0] i_cfg_index = REG_SENSOR_MIN;
    logic [SMP_W-1:0] i_cfg_data = '0;
    logic             i_valid = 1'b0;
    logic             o_ready;
    logic [SMP_W-1:0] i_light_sample = '0;
    logic             o_valid;
    logic             i_ready = 1'b0;
    logic [LVL_W-1:0] o_sensor_level;
    logic             o_level_changed;
    logic [LVL_W-1:0] o_brightness_target;

    int fail_count, pending, quiet_cycles;
    bit calm;
    int lo_bound, hi_bound;

    light_sensor_trimmed_mean_dimmer_unit uut (.*);

    light_sensor_trimmed_mean_dimmer_unit_checker chk (
        .i_clk, .i_rst_n, .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index,
        .i_cfg_data, .i_valid, .i_ready_in(o_ready), .i_light_sample,
        .i_out_valid(o_valid), .i_out_ready(i_ready), .i_sensor_level(o_sensor_level),
        .i_level_changed(o_level_changed), .i_brightness_target(o_brightness_target),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    always #2 i_clk = ~i_clk;

    // Stall the result channel at random, except during the calm stretch
    always @(negedge i_clk) begin
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 18);
    end

    // Count cycles with no beat on any channel
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("light_sensor_trimmed_mean_dimmer_unit test failed");
            $finish;
        end
    end

    // Write one register; called on a falling edge, returns on one
    task automatic write_reg(logic [IDX_W-1:0] idx, logic [SMP_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
        if (idx == REG_SENSOR_MIN) lo_bound = data;
        if (idx == REG_SENSOR_MAX) hi_bound = data;
    endtask

    // Send one sample beat, with an optional random gap first
    task automatic send_sample(logic [SMP_W-1:0] smp);
        int gap;
        gap = (!calm && $urandom_range(99) < 18) ? $urandom_range(1, 5) : 0;
        if (gap > 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid        = 1'b1;
        i_light_sample = smp;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    // Hold the sender until every awaited result has arrived
    task automatic drain();
        i_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Uniform, near the configured span, or at the extremes
    function automatic logic [SMP_W-1:0] pick_sample();
        int m, a, b;
        m = $urandom_range(99);
        a = (lo_bound < hi_bound) ? lo_bound : hi_bound;
        b = (lo_bound < hi_bound) ? hi_bound : lo_bound;
        if (m < 55) return 12'($urandom_range(4095));
        if (m < 85) return 12'($urandom_range(b, a));
        return ($urandom_range(1)) ? 12'hFFF : 12'h000;
    endfunction

    initial begin
        logic [SMP_W-1:0] a, b;
        lo_bound = 0;
        hi_bound = 4095;
        calm = 1'b0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // Directed: plain-mean fill at the extremes, then the trimmed path
        send_sample(12'hFFF);
        send_sample(12'h000);
        send_sample(12'hFFF);
        send_sample(12'hAAA);
        send_sample(12'h555);
        send_sample(12'h000);
        send_sample(12'hFFF);
        send_sample(12'h800);
        send_sample(12'h7FF);
        drain();
        // averages outside the span get clamped
        write_reg(REG_SENSOR_MIN, 12'd1000);
        write_reg(REG_SENSOR_MAX, 12'd3000);
        write_reg(REG_SENSITIVITY, 12'd200);
        write_reg(REG_USER_BRIGHTNESS, 12'd255);
        repeat (3) send_sample(12'h000);
        repeat (10) send_sample(12'hFFF);
        drain();
        // inverted span
        write_reg(REG_SENSOR_MIN, 12'd3500);
        write_reg(REG_SENSOR_MAX, 12'd200);
        write_reg(REG_USER_BRIGHTNESS, 12'd0);
        send_sample(12'd100);
        send_sample(12'd2000);
        send_sample(12'd4000);
        drain();
        // equal bounds, zero sensitivity
        write_reg(REG_SENSOR_MAX, 12'd3500);
        write_reg(REG_SENSITIVITY, 12'hF00);
        send_sample(12'd1234);
        send_sample(12'd3500);
        drain();

        // Random phases, each under fresh register settings
        for (int ph = 0; ph < 11; ph++) begin
            calm = (ph == 4);
            case ($urandom_range(3))
                0: begin a = 12'd0; b = 12'hFFF; end
                1: begin a = 12'hFFF; b = 12'd0; end
                default: begin
                    a = 12'($urandom_range(4095));
                    b = 12'($urandom_range(4095));
                end
            endcase
            write_reg(REG_SENSOR_MIN, a);
            write_reg(REG_SENSOR_MAX, b);
            write_reg(REG_SENSITIVITY, (ph % 3 == 0) ? 12'h0FF : 12'($urandom_range(4095)));
            write_reg(REG_USER_BRIGHTNESS, (ph % 3 == 1) ? 12'hF00 : 12'($urandom_range(4095)));
            for (int k = 0; k < 62; k++) send_sample(pick_sample());
            drain();
        end
        calm = 1'b0;

        repeat (20) @(posedge i_clk);
        if (fail_count == 0)
            $display("light_sensor_trimmed_mean_dimmer_unit test passed");
        else
            $display("light_sensor_trimmed_mean_dimmer_unit test failed");
        $finish;
    end

endmodule

@@ files.f @@
src/lstmd_pkg.sv
src/light_sensor_trimmed_mean_dimmer_unit.sv
src/lstmd_checker.sv
tb/sv/light_sensor_trimmed_mean_dimmer_unit_checker.sv
tb/sv/light_sensor_trimmed_mean_dimmer_unit_test.sv
